// ===== design/decimating_fir_correlator_assert.svh =====
// ----------------------------------------------------------------------------
// decimating fir correlator assertion macros
// shared property shorthands for the correlator rtl
// ----------------------------------------------------------------------------
`ifndef DECIMATING_FIR_CORRELATOR_ASSERT_SVH
`define DECIMATING_FIR_CORRELATOR_ASSERT_SVH

// same-cycle implication
`define DFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dfc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfc_pkg
// types, constants and codes shared by the decimating fir correlator
// ----------------------------------------------------------------------------
package dfc_pkg;

	localparam int MAX_TAPS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int TAP_STORE_DEPTH = 64;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT = 2'd2;

	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [6:0]  TAP_COUNT_RST  = 7'd1;
	localparam logic [8:0]  DECIMATION_RST = 9'd1;
	localparam logic [15:0] SKIP_COUNT_RST = 16'd0;

	typedef struct packed {
		logic              opcode;
		logic [5:0]        coef_index;
		logic signed [15:0] value;
		logic              last_sample;
	} dfc_in_t;

	typedef struct packed {
		logic signed [31:0] filtered_value;
		logic [15:0]        output_index;
		logic               has_value;
		logic               end_of_record;
		logic               short_record;
	} dfc_out_t;

	typedef struct packed {
		logic        has_value;
		logic        end_of_record;
		logic        short_record;
		logic [15:0] output_index;
		logic [6:0]  taps;
	} dfc_job_t;

	typedef struct packed {
		logic        we;
		logic [5:0]  addr;
		logic signed [15:0] data;
	} dfc_coef_wr_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dfc_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MAC,
		BK_DRAIN,
		BK_FINISH
	} dfc_back_state_t;

endpackage

// ===== design/dfc_front.sv =====
// ----------------------------------------------------------------------------
// dfc_front
// accepts words, holds configuration and record counters, writes the tap and
// sample stores and queues one job per result
// ----------------------------------------------------------------------------
module dfc_front import dfc_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int AW         = $clog2(MAX_TAPS) + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  dfc_in_t                       req,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output dfc_coef_wr_t                  coef_wr,
	output logic                          smp_we,
	output logic [AW-1:0]                 smp_addr,
	output logic signed [SAMPLE_BITS-1:0] smp_data,
	output logic                          push,
	output dfc_job_t                      push_job,
	output logic [AW-1:0]                 push_base,
	input  dfc_qstat_t                    qstat,
	input  logic [AW-1:0]                 head_base,
	input  logic                          back_busy,
	input  logic [AW-1:0]                 back_base
);

	localparam int     DEPTH   = 1 << AW;
	localparam int     ROOM    = DEPTH - MAX_TAPS;
	localparam longint SMP_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SMP_MIN = -SMP_MAX - 1;
	localparam logic [16:0] CNT_MAX = '1;

	logic [6:0]    tap_count_q;
	logic [8:0]    decimation_q;
	logic [15:0]   skip_count_q;
	logic [16:0]   smp_cnt_q;
	logic [7:0]    phase_q;
	logic [15:0]   out_cnt_q;
	logic [AW-1:0] wr_ptr_q;

	logic [6:0]    taps;
	logic [7:0]    dec_m1;
	logic [16:0]   first;
	logic          emit;
	logic [7:0]    phase_d;
	logic          is_short;
	logic          outstanding;
	logic [AW-1:0] oldest_base;
	logic [AW-1:0] gap;
	logic          room;
	logic          accept;
	logic          smp_acc;

	always_comb begin
		if (tap_count_q == 7'd0) begin
			taps = 7'd1;
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			taps = 7'(MAX_TAPS);
		end else begin
			taps = tap_count_q;
		end
		if (decimation_q == 9'd0) begin
			dec_m1 = 8'd0;
		end else if (decimation_q > 9'd256) begin
			dec_m1 = 8'd255;
		end else begin
			dec_m1 = 8'(decimation_q - 9'd1);
		end
	end

	assign first    = 17'(skip_count_q) + 17'(taps) - 17'd1;
	assign is_short = smp_cnt_q < (17'(taps) - 17'd1);

	always_comb begin
		emit    = 1'b0;
		phase_d = phase_q;
		if (smp_cnt_q == first) begin
			emit    = 1'b1;
			phase_d = dec_m1;
		end else if (smp_cnt_q > first) begin
			if (phase_q == 8'd0) begin
				emit    = 1'b1;
				phase_d = dec_m1;
			end else begin
				phase_d = phase_q - 8'd1;
			end
		end
	end

	// sample clamp to the window width
	always_comb begin
		if (longint'(req.value) > SMP_MAX) begin
			smp_data = SAMPLE_BITS'(SMP_MAX);
		end else if (longint'(req.value) < SMP_MIN) begin
			smp_data = SAMPLE_BITS'(SMP_MIN);
		end else begin
			smp_data = SAMPLE_BITS'(req.value);
		end
	end

	// keep the oldest pending window clear of new writes
	assign outstanding = back_busy || !qstat.empty;
	assign oldest_base = back_busy ? back_base : head_base;
	assign gap         = wr_ptr_q - oldest_base;
	assign room        = !outstanding || (int'(gap) <= ROOM);

	always_comb begin
		if (req.opcode == OP_COEF) begin
			req_ready = !outstanding;
		end else begin
			req_ready = !qstat.full && room;
		end
	end

	assign accept  = req_valid && req_ready;
	assign smp_acc = accept && (req.opcode == OP_SAMPLE);

	assign coef_wr.we   = accept && (req.opcode == OP_COEF) && (int'(req.coef_index) < MAX_TAPS);
	assign coef_wr.addr = req.coef_index;
	assign coef_wr.data = req.value;

	assign smp_we   = smp_acc;
	assign smp_addr = wr_ptr_q;

	always_comb begin
		push_job.taps          = taps;
		push_job.end_of_record = req.last_sample;
		push_job.short_record  = req.last_sample && is_short;
		push_job.has_value     = req.last_sample ? (!is_short && emit) : 1'b1;
		push_job.output_index  = (req.last_sample && is_short) ? 16'd0 : out_cnt_q;
	end

	assign push      = smp_acc && (req.last_sample || emit);
	assign push_base = wr_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= TAP_COUNT_RST;
			decimation_q <= DECIMATION_RST;
			skip_count_q <= SKIP_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAP_COUNT:  tap_count_q  <= cfg_data[6:0];
				CFG_DECIMATION: decimation_q <= cfg_data[8:0];
				CFG_SKIP_COUNT: skip_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_cnt_q <= '0;
			phase_q   <= '0;
			out_cnt_q <= '0;
			wr_ptr_q  <= '0;
		end else if (smp_acc) begin
			wr_ptr_q <= wr_ptr_q + AW'(1);
			if (req.last_sample) begin
				smp_cnt_q <= '0;
				phase_q   <= '0;
				out_cnt_q <= '0;
			end else begin
				if (smp_cnt_q != CNT_MAX) begin
					smp_cnt_q <= smp_cnt_q + 17'd1;
				end
				phase_q <= phase_d;
				if (emit) begin
					out_cnt_q <= out_cnt_q + 16'd1;
				end
			end
		end
	end

endmodule

// ===== design/dfc_queue.sv =====
// ----------------------------------------------------------------------------
// dfc_queue
// short job queue between the front and the multiply-accumulate back end
// ----------------------------------------------------------------------------
module dfc_queue import dfc_pkg::*; #(
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dfc_job_t      push_job,
	input  logic [AW-1:0] push_base,
	input  logic          pop,
	output dfc_job_t      head_job,
	output logic [AW-1:0] head_base,
	output dfc_qstat_t    qstat
);

	localparam int QPW = $clog2(QUEUE_DEPTH);

	dfc_job_t      job_mem_q  [QUEUE_DEPTH];
	logic [AW-1:0] base_mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wptr_q;
	logic [QPW-1:0] rptr_q;
	logic [QPW:0]   count_q;

	assign head_job    = job_mem_q[rptr_q];
	assign head_base   = base_mem_q[rptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == (QPW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			job_mem_q[wptr_q]  <= push_job;
			base_mem_q[wptr_q] <= push_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

endmodule

// ===== design/dfc_back.sv =====
// ----------------------------------------------------------------------------
// dfc_back
// tap and sample stores, one multiply-accumulate per tap, rounding,
// saturation and the result register
// ----------------------------------------------------------------------------
module dfc_back import dfc_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int AW         = $clog2(MAX_TAPS) + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dfc_coef_wr_t                  coef_wr,
	input  logic                          smp_we,
	input  logic [AW-1:0]                 smp_addr,
	input  logic signed [SAMPLE_BITS-1:0] smp_data,
	output logic                          pop,
	input  dfc_job_t                      job,
	input  logic [AW-1:0]                 job_base,
	input  dfc_qstat_t                    qstat,
	output logic                          busy,
	output logic [AW-1:0]                 base,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output dfc_out_t                      rsp
);

	localparam int DEPTH = 1 << AW;
	localparam int TD    = (MAX_TAPS < TAP_STORE_DEPTH) ? MAX_TAPS : TAP_STORE_DEPTH;
	localparam int TAW   = $clog2(TD);
	localparam int PW    = 16 + SAMPLE_BITS;
	localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;
	localparam int SH_W  = ACC_W - 15;

	logic signed [15:0]            coef_mem [TD];
	logic signed [SAMPLE_BITS-1:0] smp_mem  [DEPTH];

	dfc_back_state_t state_q;
	dfc_back_state_t state_d;

	dfc_job_t      job_q;
	logic [AW-1:0] base_q;
	logic [6:0]    tap_q;
	logic          v_s1;
	logic          l_s1;
	logic          z_s1;
	logic          v_s2;
	logic          l_s2;
	logic signed [15:0]            coef_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic signed [PW-1:0]          prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	dfc_out_t      rsp_q;
	logic          rsp_valid_q;

	logic          issue;
	logic          last_issue;
	logic          load_rsp;
	logic [AW-1:0] smp_ra;
	logic signed [15:0]      coef_eff;
	logic [ACC_W-1:0]        biased;
	logic signed [SH_W-1:0]  shifted;
	logic signed [63:0]      sh64;
	logic signed [31:0]      sat;

	assign last_issue = (tap_q == (job_q.taps - 7'd1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					state_d = job.has_value ? BK_MAC : BK_FINISH;
				end
			end
			BK_MAC: begin
				if (last_issue) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (v_s2 && l_s2) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		issue    = 1'b0;
		load_rsp = 1'b0;
		busy     = 1'b1;
		case (state_q)
			BK_IDLE: begin
				pop  = !qstat.empty;
				busy = 1'b0;
			end
			BK_MAC:    issue = 1'b1;
			BK_DRAIN:  ;
			BK_FINISH: load_rsp = !rsp_valid_q || rsp_ready;
			default:   busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window entry taps-1-t back from the newest sample meets tap t
	assign smp_ra = base_q - AW'(job_q.taps - 7'd1 - tap_q);

	always_ff @(posedge clk) begin
		if (coef_wr.we) begin
			coef_mem[coef_wr.addr[TAW-1:0]] <= coef_wr.data;
		end
		coef_s1 <= coef_mem[tap_q[TAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (smp_we) begin
			smp_mem[smp_addr] <= smp_data;
		end
		smp_s1 <= smp_mem[smp_ra];
	end

	assign coef_eff = z_s1 ? 16'sd0 : coef_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			l_s1 <= 1'b0;
			v_s2 <= 1'b0;
			l_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			l_s1 <= issue && last_issue;
			v_s2 <= v_s1;
			l_s2 <= l_s1;
		end
	end

	always_ff @(posedge clk) begin
		z_s1    <= (int'(tap_q) >= TD);
		prod_s2 <= coef_eff * smp_s1;
		if (pop) begin
			job_q  <= job;
			base_q <= job_base;
			tap_q  <= '0;
			acc_q  <= '0;
		end else begin
			if (issue) begin
				tap_q <= tap_q + 7'd1;
			end
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign base = base_q;

	// round half up to q.15 then saturate
	assign biased  = acc_q + ACC_W'(16384);
	assign shifted = $signed(biased[ACC_W-1:15]);
	assign sh64    = 64'(shifted);

	always_comb begin
		if (sh64 > 64'sd2147483647) begin
			sat = 32'sh7fffffff;
		end else if (sh64 < -64'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = 32'(sh64);
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.filtered_value <= job_q.has_value ? sat : 32'sd0;
			rsp_q.output_index   <= job_q.output_index;
			rsp_q.has_value      <= job_q.has_value;
			rsp_q.end_of_record  <= job_q.end_of_record;
			rsp_q.short_record   <= job_q.short_record;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/decimating_fir_correlator.sv =====
// ----------------------------------------------------------------------------
// decimating_fir_correlator
// streaming decimating correlator over q1.15 taps and samples
//
//   channel  signals                     direction  payload
//   req      req_valid req_ready req     in         dfc_in_t
//   rsp      rsp_valid rsp_ready rsp     out        dfc_out_t
//   cfg      cfg_we cfg_index cfg_data   in         register write, no wait
//
// a sample word is taken while the job queue has room; a word that yields a
// value passes through the multiply-accumulate unit, one tap per cycle over the
// taps in use, then drains; other results go straight to the result register
// a coefficient word waits until every queued job has left the back end
// sample words also stall when the oldest pending window would be overwritten
// reset clears control state only; the tap and sample stores need no clearing
// ----------------------------------------------------------------------------
module decimating_fir_correlator import dfc_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  dfc_in_t               req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output dfc_out_t              rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	`include "decimating_fir_correlator_assert.svh"

	localparam int AW = $clog2(MAX_TAPS) + 1;

	dfc_coef_wr_t                  coef_wr;
	logic                          smp_we;
	logic [AW-1:0]                 smp_addr;
	logic signed [SAMPLE_BITS-1:0] smp_data;
	logic                          push;
	dfc_job_t                      push_job;
	logic [AW-1:0]                 push_base;
	logic                          pop;
	dfc_job_t                      head_job;
	logic [AW-1:0]                 head_base;
	dfc_qstat_t                    qstat;
	logic                          back_busy;
	logic [AW-1:0]                 back_base;

	dfc_front #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef_wr   (coef_wr),
		.smp_we    (smp_we),
		.smp_addr  (smp_addr),
		.smp_data  (smp_data),
		.push      (push),
		.push_job  (push_job),
		.push_base (push_base),
		.qstat     (qstat),
		.head_base (head_base),
		.back_busy (back_busy),
		.back_base (back_base)
	);

	dfc_queue #(
		.AW (AW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.push_base (push_base),
		.pop       (pop),
		.head_job  (head_job),
		.head_base (head_base),
		.qstat     (qstat)
	);

	dfc_back #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_wr   (coef_wr),
		.smp_we    (smp_we),
		.smp_addr  (smp_addr),
		.smp_data  (smp_data),
		.pop       (pop),
		.job       (head_job),
		.job_base  (head_base),
		.qstat     (qstat),
		.busy      (back_busy),
		.base      (back_base),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`DFC_ASSERT_NOW(a_coef_when_drained, clk, arst_n, req_valid && req_ready && (req.opcode == OP_COEF), !back_busy && qstat.empty, "coefficient taken with jobs pending")
	`DFC_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !qstat.full, "job pushed into full queue")
	`DFC_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !qstat.empty, "job popped from empty queue")
	`DFC_ASSERT_NEXT(a_pop_starts_back, clk, arst_n, pop, back_busy, "back end idle after pop")

endmodule

// ===== verif/decimating_fir_correlator_tb.sv =====
// ----------------------------------------------------------------------------
// decimating_fir_correlator_tb
// self-checking bench for the decimating correlator: a queue-fed driver sends
// coefficient and sample words, an in-bench predictor computes the expected
// windowed dot products, and a monitor compares every response word in order
// across phases of register settings and idle patterns
// ----------------------------------------------------------------------------
module decimating_fir_correlator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfc_pkg::*;

	localparam int N_TAPS       = MAX_TAPS_DEF;
	localparam int DRAIN_CYCLES = 2 * MAX_TAPS_DEF + 16;
	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 160;
	localparam longint SUM_MAX  = 64'sd2147483647;
	localparam longint SUM_MIN  = -SUM_MAX - 1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	dfc_in_t               req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	dfc_out_t              rsp;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAP_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state
	logic [6:0]         cfg_taps = TAP_COUNT_RST;
	logic [8:0]         cfg_dec  = DECIMATION_RST;
	logic [15:0]        cfg_skip = SKIP_COUNT_RST;
	logic signed [15:0] tap_coef [N_TAPS];
	logic signed [15:0] win_hist [N_TAPS];
	int unsigned        rec_pos     = 0;
	int unsigned        phase_left  = 0;
	logic [15:0]        out_ordinal = '0;

	dfc_in_t  pending_words [$];
	dfc_out_t expected_rsp [$];
	dfc_out_t want_rsp;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int err_count      = 0;
	int checked_count  = 0;
	int value_count    = 0;
	int short_count    = 0;
	int record_count   = 0;
	int sample_count   = 0;
	int coef_count     = 0;

	always #10 clk = ~clk;

	decimating_fir_correlator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int unsigned eff_taps();
		if (cfg_taps == 0) return 1;
		if (cfg_taps > N_TAPS) return N_TAPS;
		return 32'(cfg_taps);
	endfunction

	function automatic int unsigned eff_dec();
		if (cfg_dec == 0) return 1;
		if (cfg_dec > 256) return 256;
		return 32'(cfg_dec);
	endfunction

	// oldest window sample meets tap 0
	function automatic logic signed [31:0] window_dot(int unsigned taps);
		longint      acc;
		longint      q;
		int unsigned t;
		acc = 0;
		for (t = 0; t < taps; t++) begin
			acc += longint'(tap_coef[t]) * longint'(win_hist[taps - 1 - t]);
		end
		q = (acc + 64'sd16384) >>> 15;
		if (q > SUM_MAX) return 32'sh7fffffff;
		if (q < SUM_MIN) return 32'sh80000000;
		return q[31:0];
	endfunction

	task automatic predict_word(input dfc_in_t w);
		int unsigned taps;
		int unsigned dec;
		int unsigned first;
		int unsigned pos;
		int          k;
		bit          emit;
		dfc_out_t    r;
		if (w.opcode == OP_COEF) begin
			tap_coef[w.coef_index] = w.value;
			return;
		end
		taps  = eff_taps();
		dec   = eff_dec();
		pos   = rec_pos;
		first = 32'(cfg_skip) + taps - 1;
		for (k = N_TAPS - 1; k > 0; k--) begin
			win_hist[k] = win_hist[k - 1];
		end
		win_hist[0] = w.value;
		emit = 1'b0;
		if (pos == first) begin
			emit       = 1'b1;
			phase_left = dec - 1;
		end else if (pos > first) begin
			if (phase_left == 0) begin
				emit       = 1'b1;
				phase_left = dec - 1;
			end else begin
				phase_left--;
			end
		end
		if (rec_pos != 32'hffff_ffff) rec_pos++;
		r = '0;
		if (w.last_sample) begin
			r.end_of_record = 1'b1;
			r.short_record  = (pos < taps - 1);
			if (!r.short_record) r.output_index = out_ordinal;
			if (!r.short_record && emit) begin
				r.filtered_value = window_dot(taps);
				r.has_value      = 1'b1;
			end
			expected_rsp.push_back(r);
			rec_pos      = 0;
			phase_left   = 0;
			out_ordinal  = '0;
			record_count++;
		end else if (emit) begin
			r.filtered_value = window_dot(taps);
			r.output_index   = out_ordinal;
			r.has_value      = 1'b1;
			expected_rsp.push_back(r);
			out_ordinal++;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] ERROR %s", $realtime, msg);
		err_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				predict_word(req);
			end
			if (!req_valid || req_ready) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req       <= pending_words.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("response word with nothing expected: %p", rsp));
				end else begin
					want_rsp = expected_rsp.pop_front();
					checked_count++;
					if (want_rsp.has_value) value_count++;
					if (want_rsp.short_record) short_count++;
					if (rsp.filtered_value !== want_rsp.filtered_value)
						report_mismatch($sformatf("filtered_value got %0d want %0d",
							rsp.filtered_value, want_rsp.filtered_value));
					if (rsp.output_index !== want_rsp.output_index)
						report_mismatch($sformatf("output_index got %0d want %0d",
							rsp.output_index, want_rsp.output_index));
					if (rsp.has_value !== want_rsp.has_value)
						report_mismatch($sformatf("has_value got %b want %b",
							rsp.has_value, want_rsp.has_value));
					if (rsp.end_of_record !== want_rsp.end_of_record)
						report_mismatch($sformatf("end_of_record got %b want %b",
							rsp.end_of_record, want_rsp.end_of_record));
					if (rsp.short_record !== want_rsp.short_record)
						report_mismatch($sformatf("short_record got %b want %b",
							rsp.short_record, want_rsp.short_record));
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_coef(input int unsigned idx, input logic [15:0] v);
		dfc_in_t w;
		w.opcode      = OP_COEF;
		w.coef_index  = idx[5:0];
		w.value       = v;
		w.last_sample = 1'($urandom_range(0, 1));
		pending_words.push_back(w);
		coef_count++;
	endtask

	task automatic push_sample(input logic [15:0] v, input bit last);
		dfc_in_t w;
		w.opcode      = OP_SAMPLE;
		w.coef_index  = 6'($urandom);
		w.value       = v;
		w.last_sample = last;
		pending_words.push_back(w);
		sample_count++;
	endtask

	task automatic wait_quiet();
		while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_record(input int unsigned len, input bit noisy, input bit pause_mid);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				push_coef($urandom_range(0, N_TAPS - 1), rand_value());
			push_sample(rand_value(), i == len - 1);
			// sender holds off mid-record until everything is back
			if (pause_mid && i == len / 2) wait_quiet();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_TAP_COUNT:  cfg_taps = data[6:0];
			CFG_DECIMATION: cfg_dec  = data[8:0];
			CFG_SKIP_COUNT: cfg_skip = data;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [15:0] t, input logic [15:0] d, input logic [15:0] s);
		write_reg(CFG_TAP_COUNT, t);
		write_reg(CFG_DECIMATION, d);
		write_reg(CFG_SKIP_COUNT, s);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned span;
		int unsigned len;
		int unsigned budget;
		int unsigned skip_part;
		int          p;
		int          i;
		logic [6:0]  t_sel;
		logic [8:0]  d_sel;
		logic [15:0] s_sel;
		for (i = 0; i < N_TAPS; i++) begin
			tap_coef[i] = '0;
			win_hist[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: one tap, every sample is an output
		push_coef(0, 16'h7fff);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'h0001, 1'b1);
		push_coef(0, 16'h8000);
		push_coef(63, 16'h7fff);
		push_sample(16'h8000, 1'b1);
		push_coef(1, 16'h04d2);
		push_coef(2, 16'hffff);
		settle();
		// short record, then a window ending on the last sample
		set_regs(16'd3, 16'd1, 16'd0);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h8000, 1'b1);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h1234, 1'b1);
		settle();
		// zero tap count and zero decimation, skip past the whole record
		set_regs(16'hff80, 16'hfe00, 16'hffff);
		push_sample(rand_value(), 1'b0);
		push_sample(rand_value(), 1'b0);
		push_sample(rand_value(), 1'b0);
		push_sample(rand_value(), 1'b1);
		settle();
		// decimation above range, end word without a value
		set_regs(16'd3, 16'd300, 16'd1);
		for (i = 0; i < 6; i++) push_sample(rand_value(), i == 5);
		settle();

		for (i = 0; i < N_TAPS; i++) push_coef(i, rand_value());

		for (p = 0; p < PHASES; p++) begin
			settle();
			if (p == 0) begin
				t_sel = 7'd64;
				d_sel = 9'd1;
				s_sel = 16'd0;
			end else if (p == 1) begin
				t_sel = 7'd1;
				d_sel = 9'd256;
				s_sel = 16'd0;
			end else if (p == 2) begin
				t_sel = 7'd127;
				d_sel = 9'd511;
				s_sel = 16'd2;
			end else begin
				case ($urandom_range(0, 4))
					0, 1: t_sel = 7'($urandom_range(1, 4));
					2: t_sel = 7'($urandom_range(1, 64));
					3: t_sel = 7'd0;
					default: t_sel = 7'($urandom_range(65, 127));
				endcase
				case ($urandom_range(0, 4))
					0: d_sel = 9'd1;
					1: d_sel = 9'($urandom_range(1, 8));
					2: d_sel = 9'($urandom_range(1, 256));
					3: d_sel = 9'd0;
					default: d_sel = 9'($urandom_range(257, 511));
				endcase
				case ($urandom_range(0, 7))
					0, 1, 2, 3: s_sel = 16'($urandom_range(0, 6));
					4, 5: s_sel = 16'd0;
					6: s_sel = 16'($urandom_range(0, 64));
					default: s_sel = 16'hffff;
				endcase
			end
			set_regs({9'($urandom), t_sel}, {7'($urandom), d_sel}, s_sel);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct  = 25;
					recv_stall_pct = 25;
				end
			endcase
			budget = 0;
			while (budget < PHASE_WORDS) begin
				skip_part = (cfg_skip > 200) ? 0 : 32'(cfg_skip);
				span = skip_part + eff_taps() + 3 * eff_dec();
				if (span > 300) span = 300;
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(1, eff_taps());
				else
					len = $urandom_range(1, span);
				push_record(len, 1'b1, p == 3 && budget == 0);
				budget += len;
			end
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived", expected_rsp.size()));
		$display("summary: %0d sample and %0d coefficient words over %0d records, %0d phases",
			sample_count, coef_count, record_count, PHASES);
		$display("summary: %0d response words checked, %0d with value, %0d short records",
			checked_count, value_count, short_count);
		if (err_count == 0) begin
			$display("decimating_fir_correlator verification clean");
		end else begin
			$display("decimating_fir_correlator verification failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("decimating_fir_correlator verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/dfc_pkg.sv
design/dfc_front.sv
design/dfc_queue.sv
design/dfc_back.sv
design/decimating_fir_correlator.sv
verif/decimating_fir_correlator_tb.sv
